// File: hw/rtl/kmb_pkg.sv
// ----------------------------------------------------------------------------
// kmb_pkg
// Shared types, register codes and the node compare used by the k-mer
// minimizer bucketing block.
// ----------------------------------------------------------------------------
package kmb_pkg;

   // Configuration port
   localparam int CSR_DATA_W  = 6;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_KMER_LENGTH      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MINIMIZER_LENGTH = 1'd1;

   localparam logic [5:0] KMER_LENGTH_RESET      = 6'd16;
   localparam logic [3:0] MINIMIZER_LENGTH_RESET = 4'd8;

   // Field widths
   localparam int CHAR_W  = 8;
   localparam int LMER_W  = 64;
   localparam int START_W = 16;

   // One window position: packed l-mer plus its membership in each half
   typedef struct packed {
      logic              lvalid;
      logic              rvalid;
      logic [LMER_W-1:0] lmer;
   } leaf_type;

   // One comparator tree node
   typedef struct packed {
      logic              valid;
      logic [LMER_W-1:0] value;
   } node_type;

   // Smaller of two candidates, a on a tie; an invalid node wins only if both are
   function automatic node_type min_node(node_type a, node_type b);
      node_type r;
      if (a.valid && (!b.valid || (a.value <= b.value))) begin
         r = a;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/kmb_if.sv
// ----------------------------------------------------------------------------
// kmb_if
// Valid/ready channels of the k-mer minimizer bucketing block: read
// characters in, minimizer results out.
// ----------------------------------------------------------------------------
interface kmb_req_if;
   logic                        valid;
   logic                        ready;
   logic [kmb_pkg::CHAR_W-1:0]  base_char;
   logic                        read_end;

   modport source (output valid, output base_char, output read_end, input ready);
   modport sink   (input valid, input base_char, input read_end, output ready);
endinterface

interface kmb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [kmb_pkg::LMER_W-1:0]  left_minimizer;
   logic [kmb_pkg::LMER_W-1:0]  right_minimizer;
   logic                        two_buckets;
   logic [kmb_pkg::START_W-1:0] kmer_start;

   modport source (output valid, output left_minimizer, output right_minimizer,
                   output two_buckets, output kmer_start, input ready);
   modport sink   (input valid, input left_minimizer, input right_minimizer,
                   input two_buckets, input kmer_start, output ready);
endinterface

// File: hw/rtl/kmb_min_tree.sv
// ----------------------------------------------------------------------------
// kmb_min_tree
// Registered binary comparator trees that find the smallest left and right
// l-mer over all window positions, one tree level per stage, followed by the
// result register. Stages advance independently so bubbles collapse.
// ----------------------------------------------------------------------------
module kmb_min_tree #(
   parameter int KMAX = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_load,
   output logic                        in_ready,
   input  kmb_pkg::leaf_type           leaves [KMAX],
   input  logic [kmb_pkg::START_W-1:0] in_start,
   kmb_rsp_if.source                   rsp
);

   localparam int LV = $clog2(KMAX);
   localparam int NL = 1 << LV;
   localparam int NN = 2 * NL - 1;

   // Heap layout: node n has children 2n+1 and 2n+2, leaves at NL-1 and up
   kmb_pkg::node_type lnode_ff [NN];
   kmb_pkg::node_type lnode_in [NN];
   kmb_pkg::node_type rnode_ff [NN];
   kmb_pkg::node_type rnode_in [NN];
   kmb_pkg::node_type lleaf    [NL];
   kmb_pkg::node_type rleaf    [NL];

   logic [kmb_pkg::START_W-1:0] start_ff [LV+1];
   logic [kmb_pkg::START_W-1:0] start_in [LV+1];
   logic [LV:0]                 stage_valid_ff;
   logic [LV:0]                 stage_valid_in;
   logic [LV:0]                 adv;
   logic                        out_adv;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [kmb_pkg::LMER_W-1:0]  rsp_left_ff;
   logic [kmb_pkg::LMER_W-1:0]  rsp_left_in;
   logic [kmb_pkg::LMER_W-1:0]  rsp_right_ff;
   logic [kmb_pkg::LMER_W-1:0]  rsp_right_in;
   logic                        rsp_two_ff;
   logic                        rsp_two_in;
   logic [kmb_pkg::START_W-1:0] rsp_start_ff;
   logic [kmb_pkg::START_W-1:0] rsp_start_in;

   // Pad the leaf row to a power of two with invalid nodes
   for (genvar p = 0; p < NL; p++) begin : g_leaf
      if (p < KMAX) begin : g_real
         assign lleaf[p] = '{valid: leaves[p].lvalid, value: leaves[p].lmer};
         assign rleaf[p] = '{valid: leaves[p].rvalid, value: leaves[p].lmer};
      end else begin : g_pad
         assign lleaf[p] = '0;
         assign rleaf[p] = '0;
      end
   end

   // Stage advance: a stage moves when it is empty or its successor moves
   always_comb begin
      out_adv = !rsp_valid_ff || rsp.ready;
      adv[LV] = !stage_valid_ff[LV] || out_adv;
      for (int s = LV - 1; s >= 0; s--) begin
         adv[s] = !stage_valid_ff[s] || adv[s+1];
      end
   end

   assign in_ready = adv[0];

   // Tree levels
   always_comb begin
      lnode_in       = lnode_ff;
      rnode_in       = rnode_ff;
      start_in       = start_ff;
      stage_valid_in = stage_valid_ff;

      if (adv[0]) begin
         for (int p = 0; p < NL; p++) begin
            lnode_in[NL-1+p] = lleaf[p];
            rnode_in[NL-1+p] = rleaf[p];
         end
         start_in[0]       = in_start;
         stage_valid_in[0] = in_load;
      end

      for (int s = 1; s <= LV; s++) begin
         if (adv[s]) begin
            for (int n = (1 << (LV - s)) - 1; n <= (2 << (LV - s)) - 2; n++) begin
               lnode_in[n] = kmb_pkg::min_node(lnode_ff[2*n+1], lnode_ff[2*n+2]);
               rnode_in[n] = kmb_pkg::min_node(rnode_ff[2*n+1], rnode_ff[2*n+2]);
            end
            start_in[s]       = start_ff[s-1];
            stage_valid_in[s] = stage_valid_ff[s-1];
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_two_in   = rsp_two_ff;
      rsp_start_in = rsp_start_ff;
      if (out_adv) begin
         rsp_valid_in = stage_valid_ff[LV];
         rsp_left_in  = lnode_ff[0].value;
         rsp_right_in = rnode_ff[0].value;
         rsp_two_in   = (lnode_ff[0].value != rnode_ff[0].value);
         rsp_start_in = start_ff[LV];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      lnode_ff     <= lnode_in;
      rnode_ff     <= rnode_in;
      start_ff     <= start_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_two_ff   <= rsp_two_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.left_minimizer  = rsp_left_ff;
   assign rsp.right_minimizer = rsp_right_ff;
   assign rsp.two_buckets     = rsp_two_ff;
   assign rsp.kmer_start      = rsp_start_ff;

`ifndef SYNTHESIS
   // Every k-mer that reaches the root had at least one candidate per half
   a_root_valid: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[LV] |-> (lnode_ff[0].valid && rnode_ff[0].valid))
      else $error("minimizer tree root holds no candidate");

   // Full pipeline behind a stalled result must refuse new items
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&stage_valid_ff) && rsp_valid_ff && !rsp.ready) |-> !in_ready)
      else $error("pipeline accepts while full and stalled");

   // An item held in the last tree stage is neither dropped nor altered
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff[LV] && !out_adv) |=>
         (stage_valid_ff[LV] && $stable(start_ff[LV])))
      else $error("stalled item lost in last tree stage");
`endif

endmodule

// File: hw/rtl/kmer_minimizer_bucketing_top.sv
// ----------------------------------------------------------------------------
// kmer_minimizer_bucketing_top
// Streams read characters through a KMAX-byte window and reports, for each
// k-mer, its left and right l-mer minimizers, a two-bucket flag and its start.
// ----------------------------------------------------------------------------
// The block takes one read character per cycle unless the result channel backs
// up, and, once k characters of the current read have arrived, gives one result
// per character, in order. The sustained rate is one item per clock when the
// output is not stalled: the window shift and the l-mer packing happen as an
// item is taken, and the minimum search is a binary comparator tree with one
// register per level, followed by the result register. The tree stages advance
// independently, so items keep entering while a finished result waits.
// Characters that close no k-mer pass through the window only and produce
// nothing. Register writes take effect on the next item.
// ----------------------------------------------------------------------------
module kmer_minimizer_bucketing_top #(
   parameter int              KMAX     = 32,
   parameter int              LMAX     = 8,
   parameter longint unsigned READ_MAX = 65535
) (
   input  logic                            clock,
   input  logic                            reset,
   kmb_req_if.sink                         req_chan,
   kmb_rsp_if.source                       rsp_chan,
   input  logic                            csr_wen,
   input  logic [kmb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kmb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FW = $clog2(KMAX + 1);
   localparam int PW = $clog2(READ_MAX + 1);
   localparam int CW = (PW > 7) ? PW : 7;

   logic [5:0]                 kmer_len_ff;
   logic [5:0]                 kmer_len_in;
   logic [3:0]                 min_len_ff;
   logic [3:0]                 min_len_in;
   logic [6:0]                 k_eff;
   logic [3:0]                 l_base;
   logic [3:0]                 l_eff;

   logic [kmb_pkg::CHAR_W-1:0] win_ff [KMAX];
   logic [kmb_pkg::CHAR_W-1:0] win_in [KMAX];
   logic [FW-1:0]              fill_ff;
   logic [FW-1:0]              fill_in;
   logic [FW-1:0]              fill_inc;
   logic [PW-1:0]              pos_ff;
   logic [PW-1:0]              pos_in;

   logic                        accept;
   logic                        emit;
   logic                        tree_ready;
   logic [CW-1:0]               start_full;
   logic [CW-1:0]               pos_ext;
   logic [CW-1:0]               km1_ext;
   logic [kmb_pkg::START_W-1:0] start;
   kmb_pkg::leaf_type           leaves [KMAX];

   // Configuration registers
   always_comb begin
      kmer_len_in = kmer_len_ff;
      min_len_in  = min_len_ff;
      if (csr_wen) begin
         unique case (csr_index)
            kmb_pkg::CSR_KMER_LENGTH:      kmer_len_in = csr_wdata;
            kmb_pkg::CSR_MINIMIZER_LENGTH: min_len_in  = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Clamp k to [2, KMAX] and l to [1, min(LMAX, k-1)]
   always_comb begin
      priority if (kmer_len_ff < 6'd2) begin
         k_eff = 7'd2;
      end else if (7'(kmer_len_ff) > 7'(KMAX)) begin
         k_eff = 7'(KMAX);
      end else begin
         k_eff = 7'(kmer_len_ff);
      end

      priority if (min_len_ff == 4'd0) begin
         l_base = 4'd1;
      end else if (min_len_ff > 4'(LMAX)) begin
         l_base = 4'(LMAX);
      end else begin
         l_base = min_len_ff;
      end

      if (7'(l_base) > (k_eff - 7'd1)) begin
         l_eff = 4'(k_eff - 7'd1);
      end else begin
         l_eff = l_base;
      end
   end

   assign accept = req_chan.valid && tree_ready;
   assign req_chan.ready = tree_ready;

   // Window shift, fill count and read position
   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      pos_in  = pos_ff;
      fill_inc = (FW'(KMAX) > fill_ff) ? (fill_ff + FW'(1)) : fill_ff;
      if (accept) begin
         for (int i = 0; i < KMAX - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[KMAX-1] = req_chan.base_char;
         if (req_chan.read_end) begin
            fill_in = '0;
            pos_in  = '0;
         end else begin
            fill_in = fill_inc;
            if (pos_ff < PW'(READ_MAX)) begin
               pos_in = pos_ff + PW'(1);
            end
         end
      end
   end

   assign emit = (7'(fill_inc) >= k_eff);

   // Start of the k-mer ending at this character, floored at zero
   always_comb begin
      pos_ext    = CW'(pos_ff);
      km1_ext    = CW'(k_eff - 7'd1);
      start_full = (pos_ext >= km1_ext) ? (pos_ext - km1_ext) : '0;
      start      = kmb_pkg::START_W'(start_full);
   end

   // Packed l-mer at each window position and its half memberships
   for (genvar p = 0; p < KMAX; p++) begin : g_pos
      for (genvar j = 0; j < 8; j++) begin : g_byte
         if ((p + j < KMAX) && (j < LMAX)) begin : g_char
            assign leaves[p].lmer[63-8*j -: 8] =
               (4'(j) < l_eff) ? win_in[p+j] : 8'd0;
         end else begin : g_zero
            assign leaves[p].lmer[63-8*j -: 8] = 8'd0;
         end
      end
      // left half: p in [KMAX-k, KMAX-1-l]; right half shifted by one
      assign leaves[p].lvalid = ((8'(p) + 8'(k_eff)) >= 8'(KMAX)) &&
                                ((8'(p) + 8'(l_eff) + 8'd1) <= 8'(KMAX));
      assign leaves[p].rvalid = ((8'(p) + 8'(k_eff)) >= (8'(KMAX) + 8'd1)) &&
                                ((8'(p) + 8'(l_eff)) <= 8'(KMAX));
   end

   kmb_min_tree #(
      .KMAX (KMAX)
   ) u_min_tree (
      .clock    (clock),
      .reset    (reset),
      .in_load  (accept && emit),
      .in_ready (tree_ready),
      .leaves   (leaves),
      .in_start (start),
      .rsp      (rsp_chan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff <= kmb_pkg::KMER_LENGTH_RESET;
         min_len_ff  <= kmb_pkg::MINIMIZER_LENGTH_RESET;
         fill_ff     <= '0;
         pos_ff      <= '0;
      end else begin
         kmer_len_ff <= kmer_len_in;
         min_len_ff  <= min_len_in;
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
      end
      win_ff <= win_in;
   end

`ifndef SYNTHESIS
   // Clamped lengths always leave at least one l-mer per half
   a_len_clamp: assert property (@(posedge clock) disable iff (reset)
      (l_eff >= 4'd1) && (7'(l_eff) < k_eff) && (k_eff >= 7'd2) &&
      (k_eff <= 7'(KMAX)))
      else $error("clamped k or l out of range");

   // The item after a read end starts a fresh read
   a_read_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.read_end) |=> ((fill_ff == '0) && (pos_ff == '0)))
      else $error("read state not cleared at read end");
`endif

endmodule

// File: dv/tb_kmer_minimizer_bucketing_top.sv
// ----------------------------------------------------------------------------
// tb_kmer_minimizer_bucketing_top
// Self-checking testbench for the k-mer minimizer bucketing block.
// Read characters are driven on the request channel with random gaps, and
// results are taken with random stalls. A scoreboard predicts each k-mer's
// minimizers, bucket flag and start from its own character window and checks
// every result in order. The run covers directed corner cases, register
// values outside their legal range, register changes inside a read, short
// reads, and one long read at full rate.
// ----------------------------------------------------------------------------
module tb_kmer_minimizer_bucketing_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              KMAX          = 32;
   localparam int              LMAX          = 8;
   localparam longint unsigned READ_MAX      = 65535;
   localparam int              PIPE_SLACK    = $clog2(KMAX) + 2 + 5;
   localparam int              RANDOM_ITEMS  = 1500;
   localparam int              LONG_READ_LEN = 300;

   // Opening read for the reset register values
   localparam logic [kmb_pkg::CHAR_W-1:0] OPEN_READ [17] = '{
      8'h41, 8'h43, 8'h47, 8'h54, 8'h00, 8'hFF, 8'h41, 8'h41, 8'h43,
      8'h43, 8'h47, 8'h47, 8'h54, 8'h54, 8'hFF, 8'h00, 8'h41
   };

   typedef struct packed {
      logic [kmb_pkg::LMER_W-1:0]  left_min;
      logic [kmb_pkg::LMER_W-1:0]  right_min;
      logic                        split;
      logic [kmb_pkg::START_W-1:0] start;
   } kmer_result_type;

   // Window predictor and queue of expected k-mer results
   class minimizer_scoreboard_type;
      bit [kmb_pkg::CHAR_W-1:0] window [KMAX];
      int                       held_chars;
      longint unsigned          next_pos;
      bit [5:0]                 kmer_len_reg;
      bit [3:0]                 lmer_len_reg;
      kmer_result_type          pending_kmers [$];
      int                       mismatches;
      int                       checked;

      function new();
         foreach (window[i]) window[i] = '0;
         held_chars   = 0;
         next_pos     = 0;
         kmer_len_reg = kmb_pkg::KMER_LENGTH_RESET;
         lmer_len_reg = kmb_pkg::MINIMIZER_LENGTH_RESET;
         mismatches   = 0;
         checked      = 0;
      endfunction

      function void write_reg(logic [kmb_pkg::CSR_INDEX_W-1:0] idx,
                              logic [kmb_pkg::CSR_DATA_W-1:0] data);
         if (idx == kmb_pkg::CSR_KMER_LENGTH) begin
            kmer_len_reg = data[5:0];
         end else if (idx == kmb_pkg::CSR_MINIMIZER_LENGTH) begin
            lmer_len_reg = data[3:0];
         end
      endfunction

      // l characters from window index first, first one in the top byte
      function bit [kmb_pkg::LMER_W-1:0] pack_lmer(int first, int l);
         bit [kmb_pkg::LMER_W-1:0] v;
         v = '0;
         for (int j = 0; j < 8; j++) begin
            v = {v[kmb_pkg::LMER_W-9:0],
                 (j < l && first + j < KMAX) ? window[first + j] : 8'h00};
         end
         return v;
      endfunction

      function bit [kmb_pkg::LMER_W-1:0] smallest_lmer(int first, int seglen, int l);
         bit [kmb_pkg::LMER_W-1:0] best;
         bit [kmb_pkg::LMER_W-1:0] cur;
         best = pack_lmer(first, l);
         for (int i = 1; i + l <= seglen; i++) begin
            cur = pack_lmer(first + i, l);
            if (cur < best) best = cur;
         end
         return best;
      endfunction

      function void take_base(bit [kmb_pkg::CHAR_W-1:0] ch, bit last);
         int              k;
         int              l;
         int              first;
         longint unsigned s;
         kmer_result_type r;
         // effective k and l after clamping
         k = kmer_len_reg;
         if (k < 2) k = 2;
         if (k > KMAX) k = KMAX;
         l = lmer_len_reg;
         if (l < 1) l = 1;
         if (l > LMAX) l = LMAX;
         if (l > k - 1) l = k - 1;
         // shift the new character in
         for (int i = 0; i < KMAX - 1; i++) window[i] = window[i + 1];
         window[KMAX - 1] = ch;
         if (held_chars < KMAX) held_chars++;
         if (held_chars >= k) begin
            first       = KMAX - k;
            r.left_min  = smallest_lmer(first, k - 1, l);
            r.right_min = smallest_lmer(first + 1, k - 1, l);
            r.split     = (r.left_min != r.right_min);
            s           = (next_pos >= longint'(k - 1)) ? next_pos - longint'(k - 1) : 0;
            r.start     = s[kmb_pkg::START_W-1:0];
            pending_kmers.insert(pending_kmers.size(), r);
         end
         // read position restarts at a read end, else saturates
         if (last) begin
            held_chars = 0;
            next_pos   = 0;
         end else if (next_pos < READ_MAX) begin
            next_pos++;
         end
      endfunction

      function void report(string field, logic [kmb_pkg::LMER_W-1:0] exp_v,
                           logic [kmb_pkg::LMER_W-1:0] act_v);
         mismatches++;
         $error("%s: expected %h, actual %h", field, exp_v, act_v);
      endfunction

      function void check_result(logic [kmb_pkg::LMER_W-1:0] lm,
                                 logic [kmb_pkg::LMER_W-1:0] rm, logic split,
                                 logic [kmb_pkg::START_W-1:0] start);
         kmer_result_type e;
         if (pending_kmers.size() == 0) begin
            report("unexpected result, left_minimizer", '0, lm);
            return;
         end
         e = pending_kmers.pop_front();
         checked++;
         if (lm !== e.left_min) report("left_minimizer", e.left_min, lm);
         if (rm !== e.right_min) report("right_minimizer", e.right_min, rm);
         if (split !== e.split) begin
            report("two_buckets", kmb_pkg::LMER_W'(e.split), kmb_pkg::LMER_W'(split));
         end
         if (start !== e.start) begin
            report("kmer_start", kmb_pkg::LMER_W'(e.start), kmb_pkg::LMER_W'(start));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                            csr_wen;
   logic [kmb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [kmb_pkg::CSR_DATA_W-1:0]  csr_wdata;

   kmb_req_if req_chan ();
   kmb_rsp_if rsp_chan ();

   minimizer_scoreboard_type board;

   bit tx_gaps_on;
   bit rx_stalls_on;
   int stall_left;
   int items_sent;
   int reads_sent;
   int csr_writes;

   kmer_minimizer_bucketing_top #(
      .KMAX     (KMAX),
      .LMAX     (LMAX),
      .READ_MAX (READ_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            board.check_result(rsp_chan.left_minimizer, rsp_chan.right_minimizer,
                               rsp_chan.two_buckets, rsp_chan.kmer_start);
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            board.take_base(req_chan.base_char, req_chan.read_end);
         end
      end
   end

   // Mostly short idle runs, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic int next_gap();
      if (!tx_gaps_on || $urandom_range(0, 99) < 65) return 0;
      return idle_len();
   endfunction

   // Result side backpressure
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 20) begin
         rsp_chan.ready <= 1'b0;
         stall_left = idle_len() - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Mostly nucleotides, some N, some arbitrary bytes and the byte extremes
   function automatic logic [kmb_pkg::CHAR_W-1:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         case ($urandom_range(0, 3))
            0: return 8'h41;
            1: return 8'h43;
            2: return 8'h47;
            default: return 8'h54;
         endcase
      end
      if (r < 78) return 8'h4E;
      if (r < 92) return kmb_pkg::CHAR_W'($urandom_range(0, 255));
      return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
   endfunction

   function automatic logic [kmb_pkg::CSR_DATA_W-1:0] pick_kmer_len();
      case ($urandom_range(0, 9))
         0: return kmb_pkg::CSR_DATA_W'($urandom_range(0, 1));
         1: return 6'd2;
         2: return 6'd32;
         3: return 6'd31;
         4: return kmb_pkg::CSR_DATA_W'($urandom_range(33, 63));
         default: return kmb_pkg::CSR_DATA_W'($urandom_range(2, 32));
      endcase
   endfunction

   function automatic logic [kmb_pkg::CSR_DATA_W-1:0] pick_lmer_len();
      case ($urandom_range(0, 7))
         0: return 6'd0;
         1: return 6'd8;
         2: return kmb_pkg::CSR_DATA_W'($urandom_range(9, 63));
         default: return kmb_pkg::CSR_DATA_W'($urandom_range(1, 8));
      endcase
   endfunction

   // Present one item, optionally after a gap, and wait until it is taken
   task automatic push_base(input logic [kmb_pkg::CHAR_W-1:0] ch, input logic last,
                            input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.base_char <= ch;
      req_chan.read_end  <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
      items_sent++;
      if (last) reads_sent++;
   endtask

   task automatic send_read(input int len, input bit closes);
      for (int i = 0; i < len; i++) begin
         push_base(pick_char(), closes && (i == len - 1), next_gap());
      end
   endtask

   // Stop sending and let every expected result come out
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.pending_kmers.size() != 0) @(negedge clock);
      repeat (PIPE_SLACK) @(negedge clock);
   endtask

   task automatic write_csr(input logic [kmb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [kmb_pkg::CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.write_reg(idx, data);
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
      csr_writes++;
   endtask

   // Main sequence
   initial begin
      int len;
      int nreads;
      int leftover;
      board              = new();
      reset              = 1'b1;
      csr_wen            = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.base_char = '0;
      req_chan.read_end  = 1'b0;
      rsp_chan.ready     = 1'b0;
      stall_left         = 0;
      tx_gaps_on         = 1'b1;
      rx_stalls_on       = 1'b1;
      items_sent         = 0;
      reads_sent         = 0;
      csr_writes         = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset register values, byte extremes and repeated l-mers
      foreach (OPEN_READ[i]) push_base(OPEN_READ[i], i == 16, next_gap());
      drain();

      // k and l below their minimum
      write_csr(kmb_pkg::CSR_KMER_LENGTH, 6'd1);
      write_csr(kmb_pkg::CSR_MINIMIZER_LENGTH, 6'd0);
      push_base(8'hFF, 1'b0, next_gap());
      push_base(8'h00, 1'b0, next_gap());
      push_base(8'h80, 1'b1, next_gap());
      drain();

      // k and l above their maximum; reads shorter than k give nothing
      write_csr(kmb_pkg::CSR_KMER_LENGTH, 6'd63);
      write_csr(kmb_pkg::CSR_MINIMIZER_LENGTH, 6'd15);
      push_base(8'h41, 1'b0, next_gap());
      push_base(8'h54, 1'b1, next_gap());
      push_base(8'h47, 1'b1, next_gap());
      drain();

      // Register change in the middle of a read, l clamped to k-1
      write_csr(kmb_pkg::CSR_KMER_LENGTH, 6'd3);
      write_csr(kmb_pkg::CSR_MINIMIZER_LENGTH, 6'd2);
      push_base(8'h47, 1'b0, next_gap());
      push_base(8'h41, 1'b0, next_gap());
      drain();
      write_csr(kmb_pkg::CSR_KMER_LENGTH, 6'd2);
      push_base(8'h54, 1'b1, next_gap());
      drain();

      // Random phases, each with its own register setting
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) != 0) write_csr(kmb_pkg::CSR_KMER_LENGTH, pick_kmer_len());
         if ($urandom_range(0, 4) != 0) begin
            write_csr(kmb_pkg::CSR_MINIMIZER_LENGTH, pick_lmer_len());
         end
         tx_gaps_on   = ($urandom_range(0, 3) != 0);
         rx_stalls_on = ($urandom_range(0, 3) != 0);
         nreads       = $urandom_range(1, 6);
         for (int r = 0; r < nreads; r++) begin
            case ($urandom_range(0, 9))
               0, 1:    len = $urandom_range(1, 40);
               9:       len = $urandom_range(60, 150);
               default: len = $urandom_range(20, 60);
            endcase
            // the last read of a phase sometimes stays open across the next write
            send_read(len, (r != nreads - 1) || ($urandom_range(0, 4) != 0));
         end
         drain();
      end

      // One long read at full rate, then a fresh read
      write_csr(kmb_pkg::CSR_KMER_LENGTH, kmb_pkg::CSR_DATA_W'($urandom_range(2, 32)));
      write_csr(kmb_pkg::CSR_MINIMIZER_LENGTH, kmb_pkg::CSR_DATA_W'($urandom_range(1, 8)));
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      send_read(LONG_READ_LEN, 1'b1);
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      send_read(40, 1'b1);

      // Wait out the tail, bounded
      req_chan.valid <= 1'b0;
      for (int w = 0; w < 5000 && board.pending_kmers.size() != 0; w++) @(negedge clock);
      repeat (PIPE_SLACK) @(negedge clock);
      leftover = board.pending_kmers.size();
      if (leftover != 0) begin
         $error("%0d expected results never arrived", leftover);
      end

      $display("Covered %0d characters in %0d reads, %0d results checked, %0d register writes.",
               items_sent, reads_sent, board.checked, csr_writes);
      $display("Included out-of-range k and l, mid-read register changes, short reads %s%0d.",
               "and a long read of ", LONG_READ_LEN);
      if (board.mismatches == 0 && leftover == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("Timeout: the run did not finish in time.");
      $display("Simulation FAILED");
      $finish;
   end

endmodule
